/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/asid_alloc_pkg.sv */
// Package with the types, constants and helper function of the ASID allocator.
`default_nettype none

package asid_alloc_pkg;

   localparam int unsigned DEFAULT_ASID_COUNT = 1024;
   localparam int unsigned ASID_W             = 10;
   localparam int unsigned STATUS_W           = 2;
   localparam int unsigned WORD_BITS          = 16;
   localparam int unsigned BIT_W              = $clog2(WORD_BITS);

   localparam logic ACTION_ALLOCATE = 1'b0;
   localparam logic ACTION_RETIRE   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_RETIRED   = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } ffs_type;

   // Finds the lowest set bit of a mark word.
   function automatic ffs_type find_first(input logic [WORD_BITS-1:0] bits);
      ffs_type r;
      r.found = |bits;
      r.idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            r.idx = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/asid_allocator_with_retire_reclaim.sv */
// Top level of the ASID allocator with retire marks and reclaim on exhaustion.
//
// The active and retired marks live in one single-port word memory, sixteen
// identifiers per word, and one find-first-free unit scans it a word at a time.
// After reset a clearing pass writes every word before the first item is taken.
// An out-of-range retire is answered straight from idle; an in-range retire
// reads its word, then modifies and writes it. An allocate reads and evaluates
// one word per step, visiting up to W+1 words with W = ceil(ASID_COUNT/16);
// when no identifier is free, a reclaim sweep reads and writes every word and a
// second search follows. The next item can be taken in the same cycle as the
// result appears, unless the result is stalled.
`default_nettype none

module asid_allocator_with_retire_reclaim
   import asid_alloc_pkg::*;
#(
   parameter int unsigned ASID_COUNT = DEFAULT_ASID_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_action,
   input  wire logic [ASID_W-1:0]   req_asid,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [ASID_W-1:0]        rsp_granted_asid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_flush_request
);

   localparam int unsigned NUM_WORDS = (ASID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned IDX_W     = WIDX_W + BIT_W;
   localparam int unsigned CNT_W     = $clog2(NUM_WORDS + 1);
   localparam int unsigned MEM_W     = 2 * WORD_BITS;

   localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(NUM_WORDS - 1);
   localparam logic [CNT_W-1:0]  LAST_VISIT = CNT_W'(NUM_WORDS);
   localparam logic [IDX_W-1:0]  FIRST_ID   = IDX_W'(1);

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_RET_RD  = 9'b000000100,
      ST_RET_WR  = 9'b000001000,
      ST_SRCH_RD = 9'b000010000,
      ST_SRCH_EV = 9'b000100000,
      ST_RECL_RD = 9'b001000000,
      ST_RECL_WR = 9'b010000000,
      ST_SPARE   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [WIDX_W-1:0]    word_ff, word_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [BIT_W-1:0]     ret_bit_ff, ret_bit_in;
   logic                 flush_ff, flush_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ASID_W-1:0]    rsp_granted_ff, rsp_granted_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_flush_ff, rsp_flush_in;

   logic [MEM_W-1:0]     mem [NUM_WORDS];
   logic [MEM_W-1:0]     rd_data_ff;
   logic                 mem_we;
   logic [MEM_W-1:0]     mem_wdata;

   logic                 req_accept;
   logic [WORD_BITS-1:0] rd_active, rd_retired;
   logic [WORD_BITS-1:0] valid_mask, visit_mask, free_bits;
   logic [WORD_BITS-1:0] ret_onehot, found_onehot;
   ffs_type              ffs;
   logic [IDX_W-1:0]     found_id;
   logic [IDX_W:0]       found_next;
   logic [IDX_W-1:0]     ret_id;
   logic                 ret_out_of_range;
   logic [WIDX_W-1:0]    start_word, word_wrap;
   logic [BIT_W-1:0]     start_bit;

   assign req_stall         = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept        = req_valid && !req_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_asid  = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_flush_request = rsp_flush_ff;

   assign rd_active  = rd_data_ff[WORD_BITS-1:0];
   assign rd_retired = rd_data_ff[MEM_W-1:WORD_BITS];
   assign start_word = ptr_ff[IDX_W-1:BIT_W];
   assign start_bit  = ptr_ff[BIT_W-1:0];
   assign word_wrap  = (word_ff == LAST_WORD) ? '0 : word_ff + WIDX_W'(1);

   assign ret_id           = IDX_W'(req_asid);
   assign ret_out_of_range = (req_asid == '0) || (32'(req_asid) >= ASID_COUNT);

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = ({1'b0, word_ff, BIT_W'(b)} != '0)
                         && (32'({1'b0, word_ff, BIT_W'(b)}) < ASID_COUNT);
         if (cnt_ff == '0) begin
            visit_mask[b] = (BIT_W'(b) >= start_bit);
         end else if (cnt_ff == LAST_VISIT) begin
            visit_mask[b] = (BIT_W'(b) < start_bit);
         end else begin
            visit_mask[b] = 1'b1;
         end
      end
   end

   assign free_bits    = ~rd_active & ~rd_retired & valid_mask & visit_mask;
   assign ffs          = find_first(free_bits);
   assign found_id     = {word_ff, ffs.idx};
   assign found_next   = {1'b0, found_id} + (IDX_W + 1)'(1);
   assign found_onehot = WORD_BITS'(1) << ffs.idx;
   assign ret_onehot   = WORD_BITS'(1) << ret_bit_ff;

   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      ret_bit_in     = ret_bit_ff;
      flush_in       = flush_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_flush_in   = rsp_flush_ff;
      mem_we         = 1'b0;
      mem_wdata      = rd_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            word_in   = word_wrap;
            if (word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACTION_RETIRE) begin
                  if (ret_out_of_range) begin
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = '0;
                     rsp_status_in  = STATUS_RANGE;
                     rsp_flush_in   = 1'b0;
                  end else begin
                     word_in    = ret_id[IDX_W-1:BIT_W];
                     ret_bit_in = ret_id[BIT_W-1:0];
                     state_in   = ST_RET_RD;
                  end
               end else begin
                  word_in  = start_word;
                  cnt_in   = '0;
                  flush_in = 1'b0;
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_RET_RD: begin
            state_in = ST_RET_WR;
         end
         ST_RET_WR: begin
            mem_we         = 1'b1;
            mem_wdata      = {rd_retired | ret_onehot, rd_active & ~ret_onehot};
            rsp_valid_in   = 1'b1;
            rsp_granted_in = '0;
            rsp_status_in  = STATUS_RETIRED;
            rsp_flush_in   = 1'b0;
            state_in       = ST_IDLE;
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_EV;
         end
         ST_SRCH_EV: begin
            if (ffs.found) begin
               mem_we         = 1'b1;
               mem_wdata      = {rd_retired, rd_active | found_onehot};
               ptr_in         = (32'(found_next) < ASID_COUNT) ? found_next[IDX_W-1:0]
                                                                : FIRST_ID;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = ASID_W'(found_id);
               rsp_status_in  = STATUS_ALLOCATED;
               rsp_flush_in   = flush_ff;
               state_in       = ST_IDLE;
            end else if (cnt_ff == LAST_VISIT) begin
               if (!flush_ff) begin
                  flush_in = 1'b1;
                  word_in  = '0;
                  state_in = ST_RECL_RD;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = '0;
                  rsp_status_in  = STATUS_EXHAUSTED;
                  rsp_flush_in   = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               word_in  = word_wrap;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_RECL_RD: begin
            state_in = ST_RECL_WR;
         end
         ST_RECL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {rd_retired & rd_active, rd_active};
            if (word_ff == LAST_WORD) begin
               word_in  = start_word;
               cnt_in   = '0;
               state_in = ST_SRCH_RD;
            end else begin
               word_in  = word_wrap;
               state_in = ST_RECL_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[word_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[word_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= FIRST_ID;
         ret_bit_ff   <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         ret_bit_ff   <= ret_bit_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_flush_ff   <= rsp_flush_in;
   end

endmodule

`default_nettype wire

/* design/asid_alloc_checker.sv */
// Port-level checker for the ASID allocator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module asid_alloc_checker
   import asid_alloc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_action,
   input wire logic [ASID_W-1:0]   req_asid,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [ASID_W-1:0]   rsp_granted_asid,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_flush_request
);

   logic rsp_retired;
   logic rsp_exhausted;
   logic rsp_range;
   logic rsp_zero_clean;
   logic rsp_zero_flush;
   logic zero_retire_taken;

   assign rsp_retired       = rsp_valid && (rsp_status == STATUS_RETIRED);
   assign rsp_exhausted     = rsp_valid && (rsp_status == STATUS_EXHAUSTED);
   assign rsp_range         = rsp_valid && (rsp_status == STATUS_RANGE);
   assign rsp_zero_clean    = (rsp_granted_asid == '0) && !rsp_flush_request;
   assign rsp_zero_flush    = (rsp_granted_asid == '0) && rsp_flush_request;
   assign zero_retire_taken = req_valid && !req_stall && (req_action == ACTION_RETIRE)
                              && (req_asid == '0);

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_ALWAYS(a_retire_clean, clock, reset, !rsp_retired || rsp_zero_clean)
   `ASSERT_ALWAYS(a_exhaust_flush, clock, reset, !rsp_exhausted || rsp_zero_flush)
   `ASSERT_NEXT(a_zero_retire, clock, reset, zero_retire_taken, rsp_range)

endmodule

bind asid_allocator_with_retire_reclaim asid_alloc_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the ASID allocator with retire marks and reclaim.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import asid_alloc_pkg::*;

   localparam int unsigned N              = DEFAULT_ASID_COUNT;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 400;

   typedef struct {
      logic [ASID_W-1:0] granted;
      status_type        status;
      logic              flush;
   } asid_result_type;

   class grant_tracker_type;
      bit              in_use[N];
      bit              retired[N];
      int unsigned     next_id;
      asid_result_type pending_grants[$];
      int unsigned     mismatches;

      function new();
         next_id    = 1;
         mismatches = 0;
      endfunction

      function int unsigned claim_free_asid();
         int unsigned span;
         int unsigned start;
         int unsigned id;
         span  = N - 1;
         start = (next_id >= 1 && next_id < N) ? next_id - 1 : 0;
         for (int unsigned k = 0; k < span; k++) begin
            id = 1 + (start + k) % span;
            if (!in_use[id] && !retired[id]) begin
               in_use[id] = 1'b1;
               next_id    = (id + 1 < N) ? id + 1 : 1;
               return id;
            end
         end
         return 0;
      endfunction

      function void note_request(input logic action, input logic [ASID_W-1:0] asid);
         asid_result_type r;
         int unsigned     got;
         r.granted = '0;
         r.flush   = 1'b0;
         if (action == ACTION_RETIRE) begin
            if (asid == 0 || asid >= N) begin
               r.status = STATUS_RANGE;
            end else begin
               in_use[asid]  = 1'b0;
               retired[asid] = 1'b1;
               r.status      = STATUS_RETIRED;
            end
         end else begin
            got = claim_free_asid();
            if (got == 0) begin
               r.flush = 1'b1;
               for (int unsigned i = 1; i < N; i++) begin
                  if (!in_use[i]) begin
                     retired[i] = 1'b0;
                  end
               end
               got = claim_free_asid();
            end
            r.status  = (got != 0) ? STATUS_ALLOCATED : STATUS_EXHAUSTED;
            r.granted = ASID_W'(got);
         end
         pending_grants.push_back(r);
      endfunction

      function void check_grant(input logic [ASID_W-1:0] granted,
                                input logic [STATUS_W-1:0] status, input logic flush);
         asid_result_type e;
         if (pending_grants.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item: granted %0d status %0d flush %0d",
                     $time, granted, status, flush);
            return;
         end
         e = pending_grants.pop_front();
         if (granted !== e.granted) begin
            mismatches++;
            $display("%0t: granted_asid expected %0d actual %0d", $time, e.granted, granted);
         end
         if (status !== e.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
         end
         if (flush !== e.flush) begin
            mismatches++;
            $display("%0t: flush_request expected %0d actual %0d", $time, e.flush, flush);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_action = ACTION_ALLOCATE;
   logic [ASID_W-1:0] req_asid   = '0;
   logic              rsp_stall  = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [ASID_W-1:0] rsp_granted_asid;
   logic [STATUS_W-1:0] rsp_status;
   logic              rsp_flush_request;

   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct     = 0;
   int unsigned       quiet_cycles  = 0;
   grant_tracker_type board         = new();

   asid_allocator_with_retire_reclaim uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_asid          (req_asid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_asid  (rsp_granted_asid),
      .rsp_status        (rsp_status),
      .rsp_flush_request (rsp_flush_request)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_request(req_action, req_asid);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_grant(rsp_granted_asid, rsp_status, rsp_flush_request);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic action, input logic [ASID_W-1:0] asid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_asid   <= asid;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [ASID_W-1:0] pick_active_asid();
      int unsigned start;
      int unsigned id;
      start = $urandom_range(N - 1, 1);
      for (int unsigned k = 0; k < N - 1; k++) begin
         id = 1 + (start - 1 + k) % (N - 1);
         if (board.in_use[id]) begin
            return ASID_W'(id);
         end
      end
      return ASID_W'(start);
   endfunction

   task automatic random_items(input int unsigned count, input int unsigned alloc_pct);
      int unsigned       sel;
      logic [ASID_W-1:0] id;
      repeat (count) begin
         if ($urandom_range(99) < alloc_pct) begin
            send_item(ACTION_ALLOCATE, ASID_W'($urandom));
         end else begin
            sel = $urandom_range(99);
            if (sel < 65) begin
               id = pick_active_asid();
            end else if (sel < 90) begin
               id = ASID_W'($urandom_range(N - 1, 1));
            end else begin
               id = '0;
            end
            send_item(ACTION_RETIRE, id);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(ACTION_ALLOCATE, '0);
      send_item(ACTION_ALLOCATE, '1);
      send_item(ACTION_ALLOCATE, ASID_W'(10'h155));
      send_item(ACTION_ALLOCATE, ASID_W'(10'h2aa));
      send_item(ACTION_RETIRE, '0);
      send_item(ACTION_RETIRE, ASID_W'(2));
      send_item(ACTION_RETIRE, ASID_W'(2));
      send_item(ACTION_RETIRE, '1);
      send_item(ACTION_RETIRE, ASID_W'(512));
      send_item(ACTION_RETIRE, ASID_W'(10'h155));
      send_item(ACTION_RETIRE, ASID_W'(10'h2aa));
      send_item(ACTION_RETIRE, ASID_W'(1));
      send_item(ACTION_ALLOCATE, '0);
      send_item(ACTION_ALLOCATE, '0);

      send_idle_pct = 28;
      stall_pct     = 55;
      random_items(320, 95);

      send_idle_pct = 55;
      stall_pct     = 28;
      random_items(200, 97);

      send_idle_pct = 0;
      stall_pct     = 0;
      random_items(216, 50);

      req_valid <= 1'b0;
      while (board.pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
